### rtl/core/ray_wall_nearest_hit_unit_assert.svh
// assertion macros used by the checker file
`ifndef RAY_WALL_NEAREST_HIT_UNIT_ASSERT_SVH
`define RAY_WALL_NEAREST_HIT_UNIT_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define RWN_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define RWN_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/rwnh_pkg.sv
// ----------------------------------------------------------------------------
// rwnh_pkg
// shared types and constants of the ray/wall nearest hit unit
// ----------------------------------------------------------------------------
`default_nettype none
package rwnh_pkg;
    localparam int DIST_W = 23;
    localparam int COUNT_W = 9;
    localparam int FIELD_W = 24;
    localparam int IDX_W = 8;
    localparam logic [DIST_W-1:0] FAR_RESET = 23'd256000;

    typedef enum logic [0:0] {
        CFG_MAX_DISTANCE = 1'b0,
        CFG_WALL_COUNT   = 1'b1
    } cfg_index_t;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_CAST = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load_ray;   // capture ray and reset best distance
        logic issue;      // present the current wall read data to the test stage
        logic div_start;
        logic sqrt_start;
        logic update;     // compare distance with best
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic crossing;
        logic div_done;
        logic sqrt_done;
    } dp_stat_t;
endpackage
`default_nettype wire

### rtl/core/ray_wall_nearest_hit_unit.sv
// ----------------------------------------------------------------------------
// ray_wall_nearest_hit_unit
// nearest strict crossing of a ray segment with a table of wall segments
// ----------------------------------------------------------------------------
// a load word (tuser kind = 0) writes one wall into the table and returns
// nothing; a cast word (kind = 1) walks the first wall_count walls and returns
// one word with the hit flag and the nearest distance, starting from
// max_distance. the walk issues one wall read per cycle while no crossing is
// in work, into a three stage side-value pipeline; a crossing rewinds the walk
// to the wall after it and runs the fraction divider and the bit-pair square
// root. one word is in work at a time. the wall table is a ram with a
// registered read.
`default_nettype none
module ray_wall_nearest_hit_unit #(
    parameter int MAX_WALLS  = 256,
    parameter int COORD_BITS = 24
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [103:0] s_tdata, // wall_index, start_x, start_y, end_x, end_y
    input  wire logic        s_tuser,  // kind
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,  // distance, zero pad
    output logic             m_tuser,  // hit
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [22:0] cfg_data
);
    localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
    localparam int CB = (COORD_BITS < 24) ? COORD_BITS : 24;
    localparam int CW = rwnh_pkg::COUNT_W;

    logic [22:0] max_distance_reg;
    logic [8:0]  wall_count_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_distance_reg <= rwnh_pkg::FAR_RESET;
            wall_count_reg   <= '0;
        end else if (cfg_valid) begin
            unique case (rwnh_pkg::cfg_index_t'(cfg_index))
                rwnh_pkg::CFG_MAX_DISTANCE: max_distance_reg <= cfg_data;
                rwnh_pkg::CFG_WALL_COUNT:   wall_count_reg   <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // saturated walk length
    logic [CW-1:0] limit;
    assign limit = (int'(wall_count_reg) < MAX_WALLS) ? wall_count_reg : CW'(MAX_WALLS);

    // field unpacking
    logic [7:0] wall_index;
    logic signed [CB-1:0] sx, sy, ex, ey;
    assign wall_index = s_tdata[7:0];
    assign sx = s_tdata[8 +: CB];
    assign sy = s_tdata[32 +: CB];
    assign ex = s_tdata[56 +: CB];
    assign ey = s_tdata[80 +: CB];

    logic load_we;
    assign load_we = s_tvalid && s_tready && (s_tuser == rwnh_pkg::KIND_LOAD)
                   && (int'(wall_index) < MAX_WALLS);

    logic [AW-1:0]   raddr;
    logic [4*CB-1:0] wall_rd;
    rwnh_ram #(.WIDTH(4 * CB), .DEPTH(MAX_WALLS)) u_walls (
        .aclk  (aclk),
        .we    (load_we),
        .waddr (AW'(wall_index)),
        .wdata ({ey, ex, sy, sx}),
        .raddr (raddr),
        .rdata (wall_rd)
    );

    rwnh_pkg::dp_cmd_t  cmd;
    rwnh_pkg::dp_stat_t stat;
    logic               hit;
    logic [22:0]        best;

    rwnh_ctrl #(.AW(AW), .CW(CW)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_kind   (s_tuser),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .limit     (limit),
        .raddr     (raddr),
        .cmd       (cmd),
        .stat      (stat)
    );

    rwnh_datapath #(.CB(CB)) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .max_distance (max_distance_reg),
        .in_sx        (sx),
        .in_sy        (sy),
        .in_ex        (ex),
        .in_ey        (ey),
        .wall_data    (wall_rd),
        .hit_reg      (hit),
        .best_reg     (best)
    );

    assign m_tdata = {1'b0, best};
    assign m_tuser = hit;
endmodule
`default_nettype wire

### rtl/core/rwnh_ram.sv
// ----------------------------------------------------------------------------
// rwnh_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module rwnh_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 256
) (
    input  wire logic                                           aclk,
    input  wire logic                                           we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]                               wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic      [WIDTH-1:0]                               rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### rtl/core/rwnh_datapath.sv
// ----------------------------------------------------------------------------
// rwnh_datapath
// crossing test, fraction divider, offset multiply and integer square root
// ----------------------------------------------------------------------------
`default_nettype none
module rwnh_datapath #(
    parameter int CB = 24
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire rwnh_pkg::dp_cmd_t               cmd,
    output rwnh_pkg::dp_stat_t                   stat,
    input  wire logic [rwnh_pkg::DIST_W-1:0]     max_distance,
    input  wire logic signed [CB-1:0]            in_sx,
    input  wire logic signed [CB-1:0]            in_sy,
    input  wire logic signed [CB-1:0]            in_ex,
    input  wire logic signed [CB-1:0]            in_ey,
    input  wire logic [4*CB-1:0]                 wall_data,
    output logic                                 hit_reg,
    output logic [rwnh_pkg::DIST_W-1:0]          best_reg
);
    localparam int DW = CB + 1;          // difference width
    localparam int PW = 2 * DW + 1;      // side value width
    localparam int MW = PW;              // magnitude width of |s0-s1|
    localparam int OW = DW;              // offset width
    localparam int SQW = 2 * OW + 2;     // radicand width, even for bit pairs
    localparam int RW = OW + 1;          // root width
    localparam int SQ_STEPS = (SQW + 1) / 2;

    logic signed [CB-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic signed [DW-1:0] rdx_reg, rdy_reg;
    logic signed [CB-1:0] bx, by, wex, wey;

    assign bx  = wall_data[CB-1:0];
    assign by  = wall_data[2*CB-1:CB];
    assign wex = wall_data[3*CB-1:2*CB];
    assign wey = wall_data[4*CB-1:3*CB];

    always_ff @(posedge aclk) begin
        if (cmd.load_ray) begin
            sx_reg  <= in_sx;
            sy_reg  <= in_sy;
            ex_reg  <= in_ex;
            ey_reg  <= in_ey;
            rdx_reg <= DW'(in_ex) - DW'(in_sx);
            rdy_reg <= DW'(in_ey) - DW'(in_sy);
        end
    end

    // stage 1: differences
    logic signed [DW-1:0] wdx_reg, wdy_reg, pbx_reg, pby_reg, qbx_reg, qby_reg;
    logic signed [DW-1:0] wsx_reg, wsy_reg, wex_s_reg, wey_s_reg;
    logic                 s1v_reg;
    always_ff @(posedge aclk) begin
        wdx_reg   <= DW'(wex) - DW'(bx);
        wdy_reg   <= DW'(wey) - DW'(by);
        pbx_reg   <= DW'(sx_reg) - DW'(bx);
        pby_reg   <= DW'(sy_reg) - DW'(by);
        qbx_reg   <= DW'(ex_reg) - DW'(bx);
        qby_reg   <= DW'(ey_reg) - DW'(by);
        wsx_reg   <= DW'(bx) - DW'(sx_reg);
        wsy_reg   <= DW'(by) - DW'(sy_reg);
        wex_s_reg <= DW'(wex) - DW'(sx_reg);
        wey_s_reg <= DW'(wey) - DW'(sy_reg);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) s1v_reg <= 1'b0;
        else s1v_reg <= cmd.issue;
    end

    // stage 2: products
    logic signed [PW-1:0] a0_reg, b0_reg, a1_reg, b1_reg, c0_reg, d0_reg, c1_reg, d1_reg;
    logic                 s2v_reg;
    always_ff @(posedge aclk) begin
        a0_reg <= PW'(wdx_reg * pby_reg);
        b0_reg <= PW'(wdy_reg * pbx_reg);
        a1_reg <= PW'(wdx_reg * qby_reg);
        b1_reg <= PW'(wdy_reg * qbx_reg);
        c0_reg <= PW'(rdx_reg * wsy_reg);
        d0_reg <= PW'(rdy_reg * wsx_reg);
        c1_reg <= PW'(rdx_reg * wey_s_reg);
        d1_reg <= PW'(rdy_reg * wex_s_reg);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) s2v_reg <= 1'b0;
        else s2v_reg <= s1v_reg;
    end

    // stage 3: side values
    logic signed [PW-1:0] s0_reg, s1_reg, t0_reg, t1_reg;
    logic                 s3v_reg;
    always_ff @(posedge aclk) begin
        s0_reg <= a0_reg - b0_reg;
        s1_reg <= a1_reg - b1_reg;
        t0_reg <= c0_reg - d0_reg;
        t1_reg <= c1_reg - d1_reg;
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) s3v_reg <= 1'b0;
        else s3v_reg <= s2v_reg;
    end

    // strict opposite signs on both pairs
    function automatic logic opposite(input logic signed [PW-1:0] p, input logic signed [PW-1:0] q);
        logic pz, qz;
        pz = (p == '0);
        qz = (q == '0);
        return !pz && !qz && (p[PW-1] != q[PW-1]);
    endfunction

    logic cross_c;
    assign cross_c = s3v_reg && opposite(s0_reg, s1_reg) && opposite(t0_reg, t1_reg);
    assign stat.crossing = cross_c;

    // fraction divider, one quotient bit a cycle
    logic [MW-1:0] num_reg, den_reg;
    logic [15:0]   q_reg;
    logic [4:0]    dcnt_reg;
    logic          dbusy_reg;
    logic          ddone_reg;    // quotient complete
    logic [MW:0]   num_sh;
    assign num_sh = {num_reg, 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
            ddone_reg <= 1'b0;
        end else begin
            ddone_reg <= dbusy_reg && (dcnt_reg == 5'd1);
            if (cmd.div_start) begin
                dbusy_reg <= 1'b1;
                dcnt_reg  <= 5'd16;
            end else if (dbusy_reg) begin
                dcnt_reg <= dcnt_reg - 5'd1;
                if (dcnt_reg == 5'd1) dbusy_reg <= 1'b0;
            end
        end
    end
    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            num_reg <= s0_reg[PW-1] ? MW'(-s0_reg) : MW'(s0_reg);
            den_reg <= (s0_reg[PW-1] ? MW'(s1_reg - s0_reg) : MW'(s0_reg - s1_reg));
            q_reg   <= '0;
        end else if (dbusy_reg) begin
            if (num_sh >= {1'b0, den_reg}) begin
                num_reg <= MW'(num_sh - {1'b0, den_reg});
                q_reg   <= {q_reg[14:0], 1'b1};
            end else begin
                num_reg <= MW'(num_sh);
                q_reg   <= {q_reg[14:0], 1'b0};
            end
        end
    end
    assign stat.div_done = ddone_reg;

    // offsets and square sums, then bit-pair square root
    logic [OW-1:0]  mdx, mdy;
    assign mdx = rdx_reg[DW-1] ? OW'(-rdx_reg) : OW'(rdx_reg);
    assign mdy = rdy_reg[DW-1] ? OW'(-rdy_reg) : OW'(rdy_reg);

    logic [OW+15:0] px_reg, py_reg;
    logic [SQW-1:0] rem_reg;
    logic [RW-1:0]  root_reg;
    logic [5:0]     qcnt_reg;
    logic [1:0]     sph_reg;     // 0 idle, 1 square, 2 sum, 3 root
    logic [2*OW-1:0] xx_reg, yy_reg;
    logic [SQW+1:0] trial;
    logic [SQW+1:0] rem_sh;

    assign rem_sh = {rem_reg, 2'b00};
    assign trial  = (SQW+2)'({root_reg, 2'b01});

    logic [SQW-1:0] rad_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sph_reg  <= '0;
            qcnt_reg <= '0;
        end else begin
            unique case (sph_reg)
                2'd0: if (cmd.sqrt_start) sph_reg <= 2'd1;
                2'd1: sph_reg <= 2'd2;
                2'd2: begin
                    sph_reg  <= 2'd3;
                    qcnt_reg <= 6'(SQ_STEPS);
                end
                2'd3: begin
                    qcnt_reg <= qcnt_reg - 6'd1;
                    if (qcnt_reg == 6'd1) sph_reg <= 2'd0;
                end
                default: sph_reg <= 2'd0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sqrt_start) begin
            px_reg <= (OW+16)'(mdx * q_reg);
            py_reg <= (OW+16)'(mdy * q_reg);
        end
        if (sph_reg == 2'd1) begin
            xx_reg <= (2*OW)'(px_reg[OW+15:16] * px_reg[OW+15:16]);
            yy_reg <= (2*OW)'(py_reg[OW+15:16] * py_reg[OW+15:16]);
        end
        if (sph_reg == 2'd2) begin
            rad_reg  <= SQW'(xx_reg) + SQW'(yy_reg);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (sph_reg == 2'd3) begin
            if ((rem_sh | (SQW+2)'(rad_reg[SQW-1 -: 2])) >= trial) begin
                rem_reg  <= SQW'((rem_sh | (SQW+2)'(rad_reg[SQW-1 -: 2])) - trial);
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end else begin
                rem_reg  <= SQW'(rem_sh | (SQW+2)'(rad_reg[SQW-1 -: 2]));
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
            rad_reg <= {rad_reg[SQW-3:0], 2'b00};
        end
    end
    assign stat.sqrt_done = (sph_reg == 2'd3) && (qcnt_reg == 6'd1);

    // result compare
    logic [RW-1:0] root_fin;
    assign root_fin = root_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg  <= 1'b0;
            best_reg <= rwnh_pkg::FAR_RESET;
        end else if (cmd.load_ray) begin
            hit_reg  <= 1'b0;
            best_reg <= max_distance;
        end else if (cmd.update) begin
            if ((RW+1)'(root_fin) < (RW+1)'(best_reg)) begin
                hit_reg  <= 1'b1;
                best_reg <= rwnh_pkg::DIST_W'(root_fin);
            end
        end
    end
endmodule
`default_nettype wire

### rtl/core/rwnh_ctrl.sv
// ----------------------------------------------------------------------------
// rwnh_ctrl
// sequencer for wall loads and ray casts
// ----------------------------------------------------------------------------
`default_nettype none
module rwnh_ctrl #(
    parameter int AW = 8,
    parameter int CW = 9
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    input  wire logic                in_kind,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire logic [CW-1:0]       limit,
    output logic [AW-1:0]            raddr,
    output rwnh_pkg::dp_cmd_t        cmd,
    input  wire rwnh_pkg::dp_stat_t  stat
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_WALK, ST_DRAIN, ST_DIV, ST_SQRT, ST_UPD, ST_OUT
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   walk_reg;     // next wall to read
    logic [CW-1:0]   resume_reg;   // wall to re-read after a crossing
    logic [1:0]      drain_reg;
    logic            out_valid_reg;

    logic            rd_ok;
    assign rd_ok = walk_reg < limit;
    assign raddr = AW'(walk_reg);
    assign in_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    logic accept_cast;
    assign accept_cast = in_valid && in_ready && (in_kind == rwnh_pkg::KIND_CAST);

    // issue goes high when the wall read in the cycle before enters the test pipeline
    logic issue_reg;
    always_comb begin
        cmd = '0;
        cmd.load_ray   = accept_cast;
        cmd.issue      = issue_reg;
        cmd.div_start  = stat.crossing && (state_reg == ST_WALK || state_reg == ST_DRAIN);
        cmd.sqrt_start = (state_reg == ST_DIV) && stat.div_done;
        cmd.update     = (state_reg == ST_UPD);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            walk_reg      <= '0;
            resume_reg    <= '0;
            drain_reg     <= '0;
            issue_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            issue_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: if (accept_cast) begin
                    walk_reg  <= '0;
                    drain_reg <= 2'd0;
                    state_reg <= ST_WALK;
                end
                ST_WALK: begin
                    if (stat.crossing) begin
                        // result of wall walk-4 crossed, rewind after it
                        resume_reg <= walk_reg - CW'(3);
                        walk_reg   <= walk_reg - CW'(3);
                        state_reg  <= ST_DIV;
                    end else if (rd_ok) begin
                        issue_reg <= 1'b1;
                        walk_reg  <= walk_reg + CW'(1);
                    end else begin
                        drain_reg <= 2'd3;
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    // wall walk-drain is the one being tested
                    if (stat.crossing) begin
                        resume_reg <= walk_reg - CW'(drain_reg - 2'd1);
                        walk_reg   <= walk_reg - CW'(drain_reg - 2'd1);
                        state_reg  <= ST_DIV;
                    end else if (drain_reg == 2'd1) begin
                        state_reg <= ST_OUT;
                    end else begin
                        drain_reg <= drain_reg - 2'd1;
                    end
                end
                ST_DIV: if (stat.div_done) state_reg <= ST_SQRT;
                ST_SQRT: if (stat.sqrt_done) state_reg <= ST_UPD;
                ST_UPD: begin
                    walk_reg  <= resume_reg;
                    state_reg <= ST_WALK;
                end
                ST_OUT: if (!out_valid_reg) begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/core/rwnh_checker.sv
// ----------------------------------------------------------------------------
// rwnh_checker
// port level checks of the ray/wall nearest hit unit
// ----------------------------------------------------------------------------
`default_nettype none
`include "ray_wall_nearest_hit_unit_assert.svh"
module rwnh_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);
    `RWN_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
    `RWN_ASSERT_IMP(a_pad, aclk, aresetn, m_tvalid, m_tdata[23] == 1'b0, "pad bit set")
    `RWN_ASSERT_IMP(a_busy, aclk, aresetn, m_tvalid, !s_tready, "accepts while result pending")
    `RWN_ASSERT_NEXT(a_cast, aclk, aresetn, s_tvalid && s_tready && s_tuser, !s_tready, "cast not held")
endmodule

bind ray_wall_nearest_hit_unit rwnh_checker u_rwnh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for ray_wall_nearest_hit_unit
// ----------------------------------------------------------------------------
// loads walls into the table and casts rays against them, with a bit-exact
// nearest-hit predictor in the bench. results are compared field by field
// against a queue of predicted hits. both stream sides idle at random.
// configuration is rewritten between phases, only while the unit is idle.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;

    typedef struct {
        logic             kind;
        logic [7:0]       slot;
        logic [23:0]      sx, sy, ex, ey;
    } ray_word_t;

    typedef struct {
        logic                        hit;
        logic [rwnh_pkg::DIST_W-1:0] near_dist;
    } hit_word_t;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [103:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [23:0] m_tdata;
    logic m_tuser;
    logic cfg_valid;
    logic cfg_ready;
    logic [0:0] cfg_index;
    logic [22:0] cfg_data;

    ray_wall_nearest_hit_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // words waiting to be sent and predicted hits waiting to come back
    ray_word_t pending_words[$];
    hit_word_t expected_hits[$];

    // bench copy of the unit's state
    longint wall_bx[256], wall_by[256], wall_ex[256], wall_ey[256];
    logic [rwnh_pkg::DIST_W-1:0]  far_limit;
    logic [rwnh_pkg::COUNT_W-1:0] walls_tested;

    int mismatches, n_loads, n_casts, n_hits, n_cfg, n_sent;
    int filled;          // slots 0..filled-1 have been written
    bit no_idle;         // phase with no gaps on either side
    bit sender_hold;
    int rx_hold_left;    // long receiver hold-off, counted by the ready driver
    int tx_gap, rx_stall;
    bit word_taken;
    ray_word_t cur_word;

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // run limit
    initial begin
        #200_000_000;
        $display("** ray_wall_nearest_hit_unit: FAILED **");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 80);
    endfunction

    function automatic int sgn(longint v);
        return (v > 0) - (v < 0);
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    // fraction num/den in Q0.16, truncated, num < den
    function automatic longint q16_fraction(longint num, longint den);
        longint q;
        q = 0;
        for (int i = 0; i < 16; i++) begin
            num = num << 1;
            q = q << 1;
            if (num >= den) begin
                num = num - den;
                q = q | 1;
            end
        end
        return q;
    endfunction

    function automatic longint floor_sqrt(longint n);
        longint res, b;
        res = 0;
        b = longint'(1) << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // nearest strict crossing over the first walls_tested walls
    function automatic hit_word_t nearest_hit(ray_word_t w);
        hit_word_t r;
        longint sx, sy, ex, ey, rdx, rdy, wdx, wdy, s0, s1, t0, t1, u, ox, oy, d, best;
        int lim;
        sx = $signed(w.sx); sy = $signed(w.sy);
        ex = $signed(w.ex); ey = $signed(w.ey);
        rdx = ex - sx; rdy = ey - sy;
        best = far_limit;
        r.hit = 1'b0;
        lim = walls_tested > 256 ? 256 : walls_tested;
        for (int i = 0; i < lim; i++) begin
            wdx = wall_ex[i] - wall_bx[i];
            wdy = wall_ey[i] - wall_by[i];
            s0 = wdx * (sy - wall_by[i]) - wdy * (sx - wall_bx[i]);
            s1 = wdx * (ey - wall_by[i]) - wdy * (ex - wall_bx[i]);
            t0 = rdx * (wall_by[i] - sy) - rdy * (wall_bx[i] - sx);
            t1 = rdx * (wall_ey[i] - sy) - rdy * (wall_ex[i] - sx);
            // touching, collinear and parallel walls never count
            if (sgn(s0) == 0 || sgn(s0) + sgn(s1) != 0) continue;
            if (sgn(t0) == 0 || sgn(t0) + sgn(t1) != 0) continue;
            u = q16_fraction(mag(s0), mag(s0 - s1));
            ox = (mag(rdx) * u) >> 16;
            oy = (mag(rdy) * u) >> 16;
            d = floor_sqrt(ox * ox + oy * oy);
            if (d < best) begin
                best = d;
                r.hit = 1'b1;
            end
        end
        r.near_dist = best[rwnh_pkg::DIST_W-1:0];
        return r;
    endfunction

    // sender: one word at a time, random gaps between words
    always @(negedge aclk) begin
        logic nv;
        nv = s_tvalid;
        if (aresetn) begin
            if (!s_tvalid || word_taken) begin
                nv = 1'b0;
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (!sender_hold && pending_words.size() > 0) begin
                    cur_word = pending_words.pop_front();
                    nv = 1'b1;
                    s_tdata <= {cur_word.ey, cur_word.ex, cur_word.sy, cur_word.sx,
                                cur_word.slot};
                    s_tuser <= cur_word.kind;
                    tx_gap = (no_idle || $urandom_range(0, 1)) ? 0 : gap_len();
                end
            end
        end
        word_taken = 1'b0;
        s_tvalid <= nv;
    end

    // receiver ready with random stalls and the occasional long hold-off
    always @(negedge aclk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!no_idle && $urandom_range(0, 9) == 0) rx_stall = gap_len();
        end
    end

    // monitor: predict on accepted words, check accepted results
    always @(posedge aclk) begin
        hit_word_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                n_cfg++;
                if (cfg_index == rwnh_pkg::CFG_MAX_DISTANCE) far_limit = cfg_data;
                else walls_tested = cfg_data[rwnh_pkg::COUNT_W-1:0];
            end
            if (s_tvalid && s_tready) begin
                word_taken = 1'b1;
                if (cur_word.kind == rwnh_pkg::KIND_LOAD) begin
                    n_loads++;
                    wall_bx[cur_word.slot] = $signed(cur_word.sx);
                    wall_by[cur_word.slot] = $signed(cur_word.sy);
                    wall_ex[cur_word.slot] = $signed(cur_word.ex);
                    wall_ey[cur_word.slot] = $signed(cur_word.ey);
                end else begin
                    n_casts++;
                    expected_hits = {expected_hits, nearest_hit(cur_word)};
                end
            end
            if (m_tvalid && m_tready) begin
                if (expected_hits.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: hit %0b distance %0d",
                                 m_tuser, m_tdata[rwnh_pkg::DIST_W-1:0]);
                end else begin
                    want = expected_hits.pop_front();
                    if (m_tuser) n_hits++;
                    if (m_tuser !== want.hit
                        || m_tdata[rwnh_pkg::DIST_W-1:0] !== want.near_dist) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected hit %0b distance %0d, got %0b %0d",
                                     want.hit, want.near_dist, m_tuser,
                                     m_tdata[rwnh_pkg::DIST_W-1:0]);
                    end
                end
            end
        end
    end

    // small coordinates keep crossings frequent, wide ones reach every bit
    function automatic logic [23:0] coord(bit wide);
        if (wide) return 24'($urandom);
        return 24'($urandom_range(0, 8191)) - 24'd4096;
    endfunction

    task automatic send(logic kind, logic [7:0] slot,
                        logic [23:0] sx, logic [23:0] sy, logic [23:0] ex, logic [23:0] ey);
        ray_word_t w;
        w.kind = kind; w.slot = slot;
        w.sx = sx; w.sy = sy; w.ex = ex; w.ey = ey;
        pending_words = {pending_words, w};
        n_sent++;
    endtask

    task automatic send_random(bit cast_only);
        bit wide;
        logic [7:0] slot;
        wide = $urandom_range(0, 9) == 0;
        if (cast_only || $urandom_range(0, 9) < 7) begin
            send(rwnh_pkg::KIND_CAST, 8'($urandom), coord(wide), coord(wide),
                 coord(wide), coord(wide));
        end else begin
            slot = 8'($urandom);
            send(rwnh_pkg::KIND_LOAD, slot, coord(wide), coord(wide), coord(wide),
                 coord(wide));
            if (slot == filled) filled++;
        end
    endtask

    // wait until the unit has drained, then let a trailing load finish
    task automatic wait_drained();
        while (pending_words.size() > 0 || s_tvalid || expected_hits.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(rwnh_pkg::cfg_index_t idx, logic [22:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int cnt, words;
        aresetn = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0; cfg_index = rwnh_pkg::CFG_MAX_DISTANCE; cfg_data = '0;
        far_limit = rwnh_pkg::FAR_RESET; walls_tested = '0;
        filled = 0; no_idle = 0; sender_hold = 0; rx_hold_left = 0;
        tx_gap = 0; rx_stall = 0; word_taken = 0;
        mismatches = 0; n_loads = 0; n_casts = 0; n_hits = 0; n_cfg = 0; n_sent = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset config: no walls tested, every cast returns the far limit
        send(rwnh_pkg::KIND_CAST, 8'hff, 24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff);
        send(rwnh_pkg::KIND_CAST, 8'h00, 24'd0, 24'd0, 24'd5120, 24'd0);
        // directed walls; ray along y = 0 from x = 0 to x = 20
        send(rwnh_pkg::KIND_LOAD, 8'd0, 24'd2560, -24'sd2560, 24'd2560, 24'd2560); // at 10
        send(rwnh_pkg::KIND_LOAD, 8'd1, 24'd0, 24'd512, 24'd5120, 24'd512);       // parallel
        send(rwnh_pkg::KIND_LOAD, 8'd2, 24'd1024, 24'd0, 24'd2048, 24'd0);        // collinear
        send(rwnh_pkg::KIND_LOAD, 8'd3, 24'd1280, 24'd0, 24'd1280, 24'd2560);     // touching
        send(rwnh_pkg::KIND_LOAD, 8'd4, 24'd1792, -24'sd256, 24'd1792, 24'd256);  // nearest
        send(rwnh_pkg::KIND_LOAD, 8'd5, 24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff);
        send(rwnh_pkg::KIND_LOAD, 8'd6, 24'd7680, -24'sd256, 24'd7680, 24'd256);  // past end
        send(rwnh_pkg::KIND_LOAD, 8'd7, 24'd2304, 24'd2560, 24'd2304, -24'sd2560); // reversed
        filled = 8;
        wait_drained();

        write_reg(rwnh_pkg::CFG_WALL_COUNT, 23'd8);
        write_reg(rwnh_pkg::CFG_MAX_DISTANCE, 23'(rwnh_pkg::FAR_RESET));
        send(rwnh_pkg::KIND_CAST, 8'd0, 24'd0, 24'd0, 24'd5120, 24'd0);
        send(rwnh_pkg::KIND_CAST, 8'd0, 24'd0, 24'd0, 24'd1792, 24'd0);   // ends on a wall
        send(rwnh_pkg::KIND_CAST, 8'd0, 24'd5120, 24'd0, 24'd0, 24'd0);   // reversed ray
        send(rwnh_pkg::KIND_CAST, 8'd0, 24'd0, 24'd0, 24'd0, 24'd0);      // zero length
        send(rwnh_pkg::KIND_CAST, 8'd0, -24'sd256, -24'sd5120, -24'sd256, 24'd5120);
        send(rwnh_pkg::KIND_CAST, 8'd0, 24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000);
        wait_drained();

        // far limit extremes
        write_reg(rwnh_pkg::CFG_MAX_DISTANCE, 23'd0);
        send(rwnh_pkg::KIND_CAST, 8'd0, 24'd0, 24'd0, 24'd5120, 24'd0);
        wait_drained();
        write_reg(rwnh_pkg::CFG_MAX_DISTANCE, 23'h7fffff);
        send(rwnh_pkg::KIND_CAST, 8'd0, 24'd0, 24'd0, 24'd5120, 24'd0);
        send(rwnh_pkg::KIND_CAST, 8'd0, 24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000);

        // fill the whole table, casts mixed in against the first walls
        for (int i = 0; i < 256; i++) begin
            send(rwnh_pkg::KIND_LOAD, 8'(i), coord(i % 16 == 0), coord(i % 16 == 0),
                 coord(i % 16 == 1), coord(i % 16 == 1));
            if (i % 8 == 0) send_random(1);
        end
        filled = 256;
        wait_drained();

        // full table with the largest far limit
        write_reg(rwnh_pkg::CFG_WALL_COUNT, 23'd256);
        for (int i = 0; i < 3; i++) send_random(1);
        wait_drained();

        for (int ph = 0; n_sent < 1200; ph++) begin
            if ($urandom_range(0, 19) == 0) begin
                cnt = 256; words = 3;
            end else begin
                cnt = $urandom_range(0, 9) == 0 ? $urandom_range(13, 64)
                                                : $urandom_range(0, 12);
                words = 40;
            end
            write_reg(rwnh_pkg::CFG_WALL_COUNT, 23'(cnt));
            case ($urandom_range(0, 3))
                0: write_reg(rwnh_pkg::CFG_MAX_DISTANCE, 23'($urandom_range(0, 2048)));
                1: write_reg(rwnh_pkg::CFG_MAX_DISTANCE, 23'h7fffff);
                2: write_reg(rwnh_pkg::CFG_MAX_DISTANCE, 23'($urandom));
                default: write_reg(rwnh_pkg::CFG_MAX_DISTANCE, 23'(rwnh_pkg::FAR_RESET));
            endcase
            no_idle = ph % 5 == 2;
            // receiver holds off for a long stretch while words keep coming
            if (ph == 3) rx_hold_left = 600;
            for (int i = 0; i < words; i++) send_random(0);
            // sender pauses mid-phase until every result is back
            if (ph % 7 == 4) begin
                sender_hold = 1;
                while (expected_hits.size() > 0) @(posedge aclk);
                sender_hold = 0;
                for (int i = 0; i < 10; i++) send_random(0);
            end
            wait_drained();
        end
        no_idle = 0;

        repeat (50) @(posedge aclk);
        $display("covered %0d loads and %0d casts (%0d with a hit), %0d register writes",
                 n_loads, n_casts, n_hits, n_cfg);
        $display("far limit and wall count taken to both extremes, %0d mismatches", mismatches);
        if (mismatches == 0 && expected_hits.size() == 0) begin
            $display("** ray_wall_nearest_hit_unit: PASSED **");
        end else begin
            $display("** ray_wall_nearest_hit_unit: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
+incdir+rtl/core
rtl/core/rwnh_pkg.sv
rtl/core/rwnh_ram.sv
rtl/core/rwnh_datapath.sv
rtl/core/rwnh_ctrl.sv
rtl/core/ray_wall_nearest_hit_unit.sv
rtl/core/rwnh_checker.sv
tb/sv/testbench.sv
